// ===== rtl/core/ccs_pkg.sv =====
// Shared types, constants and round functions of the ChaCha20 stream cipher.
package ccs_pkg;

    localparam int KEY_REGS  = 4;
    localparam int CFG_IDX_W = 8;
    localparam int NONCE_W   = 96;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] block_t;
    typedef logic [KEY_REGS-1:0][63:0] key_t;

    // One request as handed from the front to the back.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               last;
        logic               new_block;
        logic [5:0]         pos;
        logic [31:0]        counter;
        logic [NONCE_W-1:0] nonce;
    } item_t;

    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646E;
    localparam word_t SIGMA_2 = 32'h79622D32;
    localparam word_t SIGMA_3 = 32'h6B206574;

    // Sub-steps after which the state is diagonalised / restored.
    localparam logic [2:0] SUB_END_COLUMNS  = 3'd3;
    localparam logic [2:0] SUB_END_DIAGONAL = 3'd7;

    function automatic block_t make_init(input key_t key, input word_t ctr,
                                         input logic [NONCE_W-1:0] nonce);
        block_t b;
        b[0] = SIGMA_0;
        b[1] = SIGMA_1;
        b[2] = SIGMA_2;
        b[3] = SIGMA_3;
        for (int i = 0; i < KEY_REGS; i++) begin
            b[4 + 2 * i] = key[i][31:0];
            b[5 + 2 * i] = key[i][63:32];
        end
        b[12] = ctr;
        b[13] = nonce[31:0];
        b[14] = nonce[63:32];
        b[15] = nonce[95:64];
        return b;
    endfunction

    function automatic logic [3:0][31:0] quarter_round(input word_t a_in, input word_t b_in,
                                                       input word_t c_in, input word_t d_in);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t t;
        a = a_in + b_in;
        t = d_in ^ a;
        d = {t[15:0], t[31:16]};
        c = c_in + d;
        t = b_in ^ c;
        b = {t[19:0], t[31:20]};
        a = a + b;
        t = d ^ a;
        d = {t[23:0], t[31:24]};
        c = c + d;
        t = b ^ c;
        b = {t[24:0], t[31:25]};
        return {d, c, b, a};
    endfunction

    // Apply one quarter round to column 0, then rotate every row left by one
    // column so the next column comes to column 0. At the end of the column
    // half, diagonalise (row r left by r); at the end of the diagonal half, undo.
    function automatic block_t round_step(input block_t w, input logic [2:0] sub);
        logic [3:0][31:0] q;
        block_t m;
        block_t s;
        block_t d;
        q = quarter_round(w[0], w[4], w[8], w[12]);
        m = w;
        m[0]  = q[0];
        m[4]  = q[1];
        m[8]  = q[2];
        m[12] = q[3];
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                s[4 * r + c] = m[4 * r + ((c + 1) & 3)];
            end
        end
        d = s;
        if (sub == SUB_END_COLUMNS) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    d[4 * r + c] = s[4 * r + ((c + r) & 3)];
                end
            end
        end else if (sub == SUB_END_DIAGONAL) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    d[4 * r + c] = s[4 * r + ((c - r + 4) & 3)];
                end
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/ccs_front.sv =====
// Front end: accepts message bytes, tracks message and block boundaries.
module ccs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // data_byte[7:0], nonce_low[71:8], nonce_high[103:72], start_counter[135:104]
    input  logic [135:0]                  s_tdata,
    input  logic                          s_tlast,
    output logic                          q_push,
    input  logic                          q_ready,
    output ccs_pkg::item_t                q_item
);

    logic                          at_start_reg;
    logic                          at_start_next;
    logic [5:0]                    pos_reg;
    logic [5:0]                    pos_next;
    logic [31:0]                   counter_reg;
    logic [31:0]                   counter_next;
    logic [ccs_pkg::NONCE_W-1:0]   nonce_reg;
    logic [ccs_pkg::NONCE_W-1:0]   nonce_next;

    logic [5:0]                    pos_eff;
    logic [31:0]                   counter_eff;
    logic [ccs_pkg::NONCE_W-1:0]   nonce_eff;
    logic                          new_block;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        // A message's first byte reloads nonce and counter and restarts the block.
        pos_eff     = at_start_reg ? 6'd0 : pos_reg;
        counter_eff = at_start_reg ? s_tdata[135:104] : counter_reg;
        nonce_eff   = at_start_reg ? s_tdata[103:8] : nonce_reg;
        new_block   = (pos_eff == 6'd0);

        q_item.data_byte = s_tdata[7:0];
        q_item.last      = s_tlast;
        q_item.new_block = new_block;
        q_item.pos       = pos_eff;
        q_item.counter   = counter_eff;
        q_item.nonce     = nonce_eff;

        at_start_next = at_start_reg;
        pos_next      = pos_reg;
        counter_next  = counter_reg;
        nonce_next    = nonce_reg;
        if (q_push) begin
            at_start_next = s_tlast;
            pos_next      = pos_eff + 6'd1;
            counter_next  = new_block ? counter_eff + 32'd1 : counter_eff;
            nonce_next    = nonce_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
            pos_reg      <= '0;
            counter_reg  <= '0;
            nonce_reg    <= '0;
        end else begin
            at_start_reg <= at_start_next;
            pos_reg      <= pos_next;
            counter_reg  <= counter_next;
            nonce_reg    <= nonce_next;
        end
    end

endmodule

// ===== rtl/core/ccs_fifo.sv =====
// Short request queue between the front and back ends.
module ccs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_pop,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/core/ccs_back.sv =====
// Back end: keystream block generation with one quarter-round unit, byte XOR.
module ccs_back #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ccs_pkg::key_t   key,
    input  logic            q_valid,
    output logic            q_pop,
    input  ccs_pkg::item_t  q_item,
    output logic            m_tvalid,
    input  logic            m_tready,
    // out_byte[7:0]
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    localparam int STEP_COUNT = DOUBLE_ROUNDS * 8;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_COUNT - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [STEP_W-1:0]             step_reg;
    logic [STEP_W-1:0]             step_next;
    ccs_pkg::block_t               work_reg;
    ccs_pkg::block_t               work_next;
    ccs_pkg::block_t               ks_reg;
    ccs_pkg::block_t               ks_next;
    logic [7:0]                    cur_data_reg;
    logic [7:0]                    cur_data_next;
    logic                          cur_last_reg;
    logic                          cur_last_next;
    logic [5:0]                    cur_pos_reg;
    logic [5:0]                    cur_pos_next;
    logic [31:0]                   blk_counter_reg;
    logic [31:0]                   blk_counter_next;
    logic [ccs_pkg::NONCE_W-1:0]   blk_nonce_reg;
    logic [ccs_pkg::NONCE_W-1:0]   blk_nonce_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [7:0]                    m_byte_reg;
    logic [7:0]                    m_byte_next;
    logic                          m_last_reg;
    logic                          m_last_next;

    logic                          out_free;
    logic                          emit;
    logic [7:0]                    emit_data;
    logic                          emit_last;
    logic [5:0]                    emit_pos;
    ccs_pkg::word_t                ks_word;
    ccs_pkg::block_t               init_words;

    assign out_free   = !m_valid_reg || m_tready;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid && (q_item.new_block || out_free);
    assign init_words = ccs_pkg::make_init(key, blk_counter_reg, blk_nonce_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        work_next        = work_reg;
        ks_next          = ks_reg;
        cur_data_next    = cur_data_reg;
        cur_last_next    = cur_last_reg;
        cur_pos_next     = cur_pos_reg;
        blk_counter_next = blk_counter_reg;
        blk_nonce_next   = blk_nonce_reg;
        emit             = 1'b0;
        emit_data        = cur_data_reg;
        emit_last        = cur_last_reg;
        emit_pos         = cur_pos_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    if (q_item.new_block) begin
                        cur_data_next    = q_item.data_byte;
                        cur_last_next    = q_item.last;
                        cur_pos_next     = q_item.pos;
                        blk_counter_next = q_item.counter;
                        blk_nonce_next   = q_item.nonce;
                        work_next        = ccs_pkg::make_init(key, q_item.counter,
                                                              q_item.nonce);
                        step_next        = '0;
                        state_next       = ST_ROUND;
                    end else begin
                        emit      = 1'b1;
                        emit_data = q_item.data_byte;
                        emit_last = q_item.last;
                        emit_pos  = q_item.pos;
                    end
                end
            end
            ST_ROUND: begin
                work_next = ccs_pkg::round_step(work_reg, step_reg[2:0]);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 16; i++) begin
                    ks_next[i] = work_reg[i] + init_words[i];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        ks_word = ks_reg[emit_pos[5:2]];

        m_valid_next = m_valid_reg && !m_tready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = emit_data ^ ks_word[{emit_pos[1:0], 3'b000} +: 8];
            m_last_next  = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg        <= work_next;
        ks_reg          <= ks_next;
        cur_data_reg    <= cur_data_next;
        cur_last_reg    <= cur_last_next;
        cur_pos_reg     <= cur_pos_next;
        blk_counter_reg <= blk_counter_next;
        blk_nonce_reg   <= blk_nonce_next;
        m_byte_reg      <= m_byte_next;
        m_last_reg      <= m_last_next;
    end

    a_new_block_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.new_block) |-> (q_item.pos == 6'd0))
        else $error("block generation requested away from a block boundary");

    a_reuse_inside_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_item.new_block) |-> (q_item.pos != 6'd0))
        else $error("stale keystream used at a block boundary");

    a_round_to_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && step_reg == STEP_LAST) |=> (state_reg == ST_FINAL))
        else $error("round sequence did not finish after the last step");

    a_final_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) |=> (state_reg == ST_EMIT && !q_pop))
        else $error("keystream add not followed by the pending byte");

endmodule

// ===== rtl/core/chacha20_stream_cipher.sv =====
// ChaCha20 byte stream cipher top level: key registers, front end, queue, back end.
//
// Usage: write the 256-bit key through the cfg channel (index 0..3, 64 bits
// each, little-endian key bytes; other indexes are ignored) while idle. Send
// message bytes on the s_ channel; tlast marks a message's final byte. The
// nonce and start counter in s_tdata are sampled on a message's first byte
// only. Each byte comes back on the m_ channel XORed with the keystream, with
// tlast copied through, in order and one result per request.
// A byte inside a 64-byte block passes through the queue and the result register
// to m_tvalid. A byte at a block boundary waits for block generation: one
// quarter round per cycle on a single shared unit for every double round,
// then the final add and the result register.
// Throughput: one byte per cycle within a block while m_tready stays high.
// Reset: the block waits for a message start, key registers read zero.
// When the receiver stalls, the result register holds; the queue fills and
// s_tready falls once QUEUE_DEPTH requests are waiting.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10,
    parameter int QUEUE_DEPTH   = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte[7:0], nonce_low[71:8], nonce_high[103:72], start_counter[135:104]
    input  logic [135:0]                   s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte[7:0]
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast
);

    localparam int ITEM_W = $bits(ccs_pkg::item_t);

    ccs_pkg::key_t   key_reg;
    ccs_pkg::key_t   key_next;
    logic            push;
    logic            push_ready;
    ccs_pkg::item_t  push_item;
    logic            pop_valid;
    logic            pop;
    ccs_pkg::item_t  pop_item;

    assign cfg_ready = 1'b1;

    always_comb begin
        key_next = key_reg;
        // Drop writes beyond the key registers.
        if (cfg_valid && (cfg_index < ccs_pkg::CFG_IDX_W'(ccs_pkg::KEY_REGS))) begin
            key_next[cfg_index[1:0]] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    ccs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (push),
        .q_ready  (push_ready),
        .q_item   (push_item)
    );

    ccs_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (push_ready),
        .in_data   (push_item),
        .out_valid (pop_valid),
        .out_pop   (pop),
        .out_data  (pop_item)
    );

    ccs_back #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key      (key_reg),
        .q_valid  (pop_valid),
        .q_pop    (pop),
        .q_item   (pop_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/ccs_cipher_checker.sv =====
// Checker for the ChaCha20 stream cipher: predicts each output byte and compares it.
`timescale 1ns / 100ps

module ccs_cipher_checker #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ccs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // data_byte[7:0], nonce_low[71:8], nonce_high[103:72], start_counter[135:104]
    input  logic [135:0]                  s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // out_byte[7:0]
    input  logic [7:0]                    m_tdata,
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            bytes_in_flight
);

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       end_of_msg;
    } cipher_out_t;

    ccs_pkg::key_t               key_shadow;
    ccs_pkg::block_t             keystream;
    ccs_pkg::word_t              next_counter;
    logic [ccs_pkg::NONCE_W-1:0] msg_nonce;
    logic [5:0]                  byte_pos;
    logic                        msg_start;
    cipher_out_t                 expected_bytes[$];
    int                          results_seen;

    function automatic ccs_pkg::word_t rotl(input ccs_pkg::word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Returns {a, b, c, d} after one quarter round.
    function automatic logic [127:0] mix(input ccs_pkg::word_t a, input ccs_pkg::word_t b,
                                         input ccs_pkg::word_t c, input ccs_pkg::word_t d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    function automatic ccs_pkg::block_t chacha_block(input ccs_pkg::key_t k,
                                                     input ccs_pkg::word_t ctr,
                                                     input logic [ccs_pkg::NONCE_W-1:0] n);
        ccs_pkg::word_t  init[16];
        ccs_pkg::word_t  x[16];
        ccs_pkg::block_t res;
        int     ia;
        int     ib;
        int     ic;
        int     id;
        int     j;
        init[0] = ccs_pkg::SIGMA_0;
        init[1] = ccs_pkg::SIGMA_1;
        init[2] = ccs_pkg::SIGMA_2;
        init[3] = ccs_pkg::SIGMA_3;
        for (int i = 0; i < ccs_pkg::KEY_REGS; i++) begin
            init[4 + 2 * i] = k[i][31:0];
            init[5 + 2 * i] = k[i][63:32];
        end
        init[12] = ctr;
        init[13] = n[31:0];
        init[14] = n[63:32];
        init[15] = n[95:64];
        for (int i = 0; i < 16; i++) x[i] = init[i];
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            for (int q = 0; q < 8; q++) begin
                // first four are columns, last four diagonals
                j  = q & 3;
                ia = j;
                ib = (q < 4) ? 4 + j  : 4 + ((j + 1) & 3);
                ic = (q < 4) ? 8 + j  : 8 + ((j + 2) & 3);
                id = (q < 4) ? 12 + j : 12 + ((j + 3) & 3);
                {x[ia], x[ib], x[ic], x[id]} = mix(x[ia], x[ib], x[ic], x[id]);
            end
        end
        for (int i = 0; i < 16; i++) res[i] = x[i] + init[i];
        return res;
    endfunction

    always @(posedge aclk) begin
        cipher_out_t want;
        logic [7:0]  ks_byte;
        if (!aresetn) begin
            key_shadow     = '0;
            keystream      = '0;
            next_counter   = '0;
            msg_nonce      = '0;
            byte_pos       = '0;
            msg_start      = 1'b1;
            mismatch_count = 0;
            results_seen   = 0;
            expected_bytes.delete();
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < ccs_pkg::KEY_REGS) begin
                key_shadow[cfg_index[1:0]] = cfg_data;
            end
            // compare before taking the new request: a result never follows its
            // own request in the same cycle
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result with no request waiting: byte %02h last %0b",
                                 $realtime, m_tdata, m_tlast);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.cipher_byte || m_tlast !== want.end_of_msg) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result %0d: byte exp %02h got %02h, last exp %0b got %0b",
                                     $realtime, results_seen, want.cipher_byte, m_tdata,
                                     want.end_of_msg, m_tlast);
                        end
                        mismatch_count++;
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                if (msg_start) begin
                    msg_nonce    = s_tdata[103:8];
                    next_counter = s_tdata[135:104];
                    byte_pos     = '0;
                end
                if (byte_pos == 6'd0) begin
                    keystream    = chacha_block(key_shadow, next_counter, msg_nonce);
                    next_counter = next_counter + 32'd1;
                end
                ks_byte          = keystream[byte_pos[5:2]][byte_pos[1:0] * 8 +: 8];
                want.cipher_byte = s_tdata[7:0] ^ ks_byte;
                want.end_of_msg  = s_tlast;
                expected_bytes.push_back(want);
                byte_pos  = byte_pos + 6'd1;
                msg_start = s_tlast;
            end
        end
        bytes_in_flight = expected_bytes.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the ChaCha20 stream cipher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int DOUBLE_ROUNDS = 10;

    localparam logic [ccs_pkg::CFG_IDX_W-1:0] KEY_IDX_0     = 8'd0;
    localparam logic [ccs_pkg::CFG_IDX_W-1:0] KEY_IDX_1     = 8'd1;
    localparam logic [ccs_pkg::CFG_IDX_W-1:0] KEY_IDX_2     = 8'd2;
    localparam logic [ccs_pkg::CFG_IDX_W-1:0] KEY_IDX_3     = 8'd3;
    localparam logic [ccs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;
    localparam logic [ccs_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

    localparam int LONG_HOLD_AFTER  = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 100;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ccs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0]                   cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [135:0]                  s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;
    logic                          m_tlast;

    int mismatch_count;
    int bytes_in_flight;
    int results_taken;
    int burst_left;
    int bytes_sent;

    logic [ccs_pkg::CFG_IDX_W-1:0] cfg_idx_q[$];
    logic [63:0]                   cfg_dat_q[$];

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    ccs_cipher_checker #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .bytes_in_flight (bytes_in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("FAIL chacha20_stream_cipher");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            results_taken <= 0;
        end else if (m_tvalid && m_tready) begin
            results_taken <= results_taken + 1;
        end
    end

    // Receiver: stretches of random back-pressure, plus one long hold-off.
    initial begin
        int  mode;
        int  mode_left;
        bit  held;
        mode_left = 0;
        mode      = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_taken >= LONG_HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_key(input ccs_pkg::key_t k);
        cfg_idx_q.push_back(KEY_IDX_0); cfg_dat_q.push_back(k[0]);
        cfg_idx_q.push_back(KEY_IDX_1); cfg_dat_q.push_back(k[1]);
        cfg_idx_q.push_back(KEY_IDX_2); cfg_dat_q.push_back(k[2]);
        cfg_idx_q.push_back(KEY_IDX_3); cfg_dat_q.push_back(k[3]);
    endtask

    // Write every queued register back to back, then drop valid.
    task automatic cfg_flush();
        while (cfg_idx_q.size() != 0) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_q.pop_front();
            cfg_data  <= cfg_dat_q.pop_front();
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic l, input logic [63:0] nl,
                             input logic [31:0] nh, input logic [31:0] ctr);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ctr, nh, nl, d};
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    // Stop offering and hold until every request has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (bytes_in_flight != 0);
    endtask

    task automatic send_message(input int len, input logic [31:0] ctr, input logic [63:0] nl,
                                input logic [31:0] nh, input bit close);
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                send_byte(8'($urandom), close && len == 1, nl, nh, ctr);
            end else begin
                // nonce and counter fields are ignored past the first byte
                send_byte(8'($urandom), close && i == len - 1, rand64(), $urandom, $urandom);
            end
        end
    endtask

    task automatic random_messages(input int count);
        int          target;
        int          len;
        int          pick;
        logic [31:0] ctr;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = $urandom_range(1, 8);
            end else if (pick < 9) begin
                len = $urandom_range(9, 80);
            end else begin
                len = $urandom_range(100, 200);
            end
            case ($urandom_range(0, 7))
                0:       ctr = 32'h0;
                1:       ctr = 32'hFFFF_FFFF;
                2:       ctr = 32'hFFFF_FFFF - $urandom_range(1, 3);
                default: ctr = $urandom;
            endcase
            send_message(len, ctr, rand64(), $urandom, 1'b1);
        end
    endtask

    initial begin
        ccs_pkg::key_t k;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset key: field extremes, one-byte messages, ignored fields past the start.
        send_byte(8'h00, 1'b1, 64'h0, 32'h0, 32'h0);
        send_byte(8'hFF, 1'b1, '1, '1, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b0, rand64(), $urandom, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0, '1, '1, 32'h0);
        send_byte(8'hA5, 1'b0, '0, '0, '1);
        send_byte(8'h5A, 1'b1, '1, '1, '1);
        send_byte(8'h3C, 1'b0, 64'h0, 32'h0, 32'h1);
        send_byte(8'hC3, 1'b1, '1, '1, '1);
        wait_drained();

        // Ascending key bytes, plus writes to unused indexes that must be dropped.
        k[0] = 64'h0706_0504_0302_0100;
        k[1] = 64'h0F0E_0D0C_0B0A_0908;
        k[2] = 64'h1716_1514_1312_1110;
        k[3] = 64'h1F1E_1D1C_1B1A_1918;
        queue_key(k);
        cfg_idx_q.push_back(CFG_IDX_SPARE); cfg_dat_q.push_back(rand64());
        cfg_idx_q.push_back(CFG_IDX_TOP);   cfg_dat_q.push_back('1);
        cfg_flush();
        // wrap the block counter across three blocks
        send_message(130, 32'hFFFF_FFFF, rand64(), $urandom, 1'b1);
        random_messages(250);
        wait_drained();

        k = '1;
        queue_key(k);
        cfg_flush();
        random_messages(250);
        wait_drained();

        // Change the key part way through a message: takes effect at the next block.
        k = {rand64(), rand64(), rand64(), rand64()};
        queue_key(k);
        cfg_flush();
        send_message(40, $urandom, rand64(), $urandom, 1'b0);
        wait_drained();
        k = {rand64(), rand64(), rand64(), rand64()};
        queue_key(k);
        cfg_flush();
        send_message(60, $urandom, rand64(), $urandom, 1'b1);
        random_messages(200);
        wait_drained();

        k = '0;
        queue_key(k);
        cfg_flush();
        random_messages(150);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && bytes_in_flight == 0) begin
            $display("PASS chacha20_stream_cipher");
        end else begin
            $display("FAIL chacha20_stream_cipher");
        end
        $finish;
    end

endmodule
